>>> hdl/tcl_pkg.sv
// ----------------------------------------------------------------------------
// tcl_pkg
// Shared types, token kind codes and character-class helpers for the
// token classifier lexer.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // Pending token store depth (supported range 6 to 8)
    localparam int MAX_TOKEN_CHARS = 8;
    localparam int IDX_W           = $clog2(MAX_TOKEN_CHARS);
    localparam int CNT_W           = 4;
    localparam int NUM_WORDS       = 14;
    localparam int WORD_MAX_CHARS  = 6;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

    // Token kind codes; keywords and symbols follow the word table order
    localparam logic [4:0] KIND_VAR    = 5'd0;
    localparam logic [4:0] KIND_IDENT  = 5'd14;
    localparam logic [4:0] KIND_NUMBER = 5'd15;
    localparam logic [4:0] KIND_ERROR  = 5'd16;
    localparam logic [4:0] KIND_END    = 5'd17;

    // Delimiter bytes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    typedef logic [MAX_TOKEN_CHARS-1:0][7:0] t_token_bytes;

    typedef struct packed {
        logic [7:0] char_in;
        logic       end_flag;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  token_kind;
        logic [30:0] number_value;
        logic [63:0] name_chars;
        logic [3:0]  name_length;
        logic        overflow;
        logic        last;
    } t_out_item;

    // Classified token, everything but the last flag
    typedef struct packed {
        logic [4:0]  kind;
        logic [30:0] number_value;
        logic [63:0] name_chars;
        logic [3:0]  name_length;
        logic        overflow;
    } t_token;

    // State of the token being collected
    typedef struct packed {
        t_token_bytes     bytes;
        logic [CNT_W-1:0] count;
        logic             too_long;
        logic             all_digits;
        logic             ident_shape;
        logic [30:0]      acc;
        logic             saturated;
    } t_tok_state;

    // Output queue entry: an optional token followed by an optional end token
    typedef struct packed {
        logic   has_tok;
        logic   has_end;
        t_token tok;
    } t_entry;

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Keyword and symbol text, right aligned (last character in low byte)
    function automatic logic [8*WORD_MAX_CHARS-1:0] word_text(input int k);
        logic [8*WORD_MAX_CHARS-1:0] t;
        case (k)
            0:       t = 48'("var");
            1:       t = 48'("const");
            2:       t = 48'("lire");
            3:       t = 48'("ecrire");
            4:       t = 48'("-");
            5:       t = 48'("+");
            6:       t = 48'("/");
            7:       t = 48'("*");
            8:       t = 48'(",");
            9:       t = 48'(";");
            10:      t = 48'("(");
            11:      t = 48'(")");
            12:      t = 48'("=");
            13:      t = 48'(":=");
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [CNT_W-1:0] word_len(input int k);
        logic [CNT_W-1:0] n;
        case (k)
            0:       n = CNT_W'(3);
            1:       n = CNT_W'(5);
            2:       n = CNT_W'(4);
            3:       n = CNT_W'(6);
            13:      n = CNT_W'(2);
            default: n = CNT_W'(1);
        endcase
        return n;
    endfunction

endpackage

>>> hdl/token_classifier_lexer_core.sv
// ----------------------------------------------------------------------------
// token_classifier_lexer_core
// Whitespace-delimited lexer: collects source bytes into tokens and emits
// classified tokens plus an end token at end of input.
// ----------------------------------------------------------------------------
//  channel | valid   | ready   | payload             | item
//  --------+---------+---------+---------------------+-------------------------
//  input   | i_valid | o_ready | i_data (t_in_item)  | one source byte or end
//  output  | o_valid | i_ready | o_data (t_out_item) | one classified token
//
// One input item is taken per cycle while o_ready is high; token state
// updates on the same edge. A delimiter or end item that closes a token is
// classified in that cycle and written into a two-entry registered output
// queue. An end item with a token pending gives the token, then the end
// token. o_ready drops only while the second queue entry is occupied.
// Reset (synchronous, active low) clears token state and queue.
// ----------------------------------------------------------------------------
module token_classifier_lexer_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tcl_pkg::t_in_item   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output tcl_pkg::t_out_item  o_data
);

    tcl_pkg::t_tok_state r_st, n_st;
    tcl_pkg::t_entry     r_q0, n_q0;
    tcl_pkg::t_entry     r_q1, n_q1;
    tcl_pkg::t_token     cls_tok;
    tcl_pkg::t_entry     new_entry;

    logic        in_acc;
    logic        out_acc;
    logic        is_delim;
    logic        pending;
    logic        push;
    logic        dig;
    logic [34:0] acc_next;
    logic [tcl_pkg::IDX_W-1:0] wr_idx;

    assign o_ready  = !(r_q1.has_tok || r_q1.has_end);
    assign in_acc   = i_valid && o_ready;
    assign o_valid  = r_q0.has_tok || r_q0.has_end;
    assign out_acc  = o_valid && i_ready;

    assign is_delim = (i_data.char_in == tcl_pkg::CHAR_SPACE) ||
                      (i_data.char_in == tcl_pkg::CHAR_NEWLINE);
    assign pending  = (r_st.count != '0);
    assign dig      = tcl_pkg::is_digit(i_data.char_in);
    assign wr_idx   = r_st.count[tcl_pkg::IDX_W-1:0];

    // Multiply-by-ten accumulate of the next digit
    assign acc_next = 35'({r_st.acc, 3'b000}) + 35'({r_st.acc, 1'b0}) +
                      35'(i_data.char_in[3:0]);

    tcl_classify u_classify (
        .i_st    (r_st),
        .o_token (cls_tok)
    );

    // Token state update
    always_comb begin
        n_st = r_st;
        if (in_acc) begin
            if (i_data.end_flag || is_delim) begin
                n_st.count       = '0;
                n_st.too_long    = 1'b0;
                n_st.all_digits  = 1'b1;
                n_st.ident_shape = 1'b1;
                n_st.acc         = '0;
                n_st.saturated   = 1'b0;
            end else begin
                if (int'(r_st.count) < tcl_pkg::MAX_TOKEN_CHARS) begin
                    n_st.bytes[wr_idx] = i_data.char_in;
                    n_st.count         = r_st.count + 1'b1;
                end else begin
                    n_st.too_long = 1'b1;
                end
                if (!pending) begin
                    n_st.ident_shape = tcl_pkg::is_letter(i_data.char_in);
                end else if (!tcl_pkg::is_letter(i_data.char_in) && !dig) begin
                    n_st.ident_shape = 1'b0;
                end
                if (!dig) begin
                    n_st.all_digits = 1'b0;
                end else if (!r_st.saturated) begin
                    if (acc_next > 35'(tcl_pkg::NUM_MAX)) begin
                        n_st.acc       = tcl_pkg::NUM_MAX;
                        n_st.saturated = 1'b1;
                    end else begin
                        n_st.acc = acc_next[30:0];
                    end
                end
            end
        end
    end

    // New queue entry for a closing delimiter or an end item
    always_comb begin
        new_entry         = '0;
        new_entry.tok     = cls_tok;
        new_entry.has_tok = pending;
        new_entry.has_end = i_data.end_flag;
        push = in_acc && (i_data.end_flag || (is_delim && pending));
    end

    // Output queue: q0 drives the port, q1 is the skid entry
    always_comb begin
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (out_acc) begin
            if (r_q0.has_tok && r_q0.has_end) begin
                // token delivered, end token still owed
                n_q0.has_tok = 1'b0;
            end else begin
                n_q0 = r_q1;
                n_q1 = '0;
            end
        end
        if (push) begin
            if (n_q0.has_tok || n_q0.has_end) begin
                n_q1 = new_entry;
            end else begin
                n_q0 = new_entry;
            end
        end
    end

    // Output payload from the head entry
    always_comb begin
        o_data = '0;
        if (r_q0.has_tok) begin
            o_data.token_kind   = r_q0.tok.kind;
            o_data.number_value = r_q0.tok.number_value;
            o_data.name_chars   = r_q0.tok.name_chars;
            o_data.name_length  = r_q0.tok.name_length;
            o_data.overflow     = r_q0.tok.overflow;
            o_data.last         = !r_q0.has_end;
        end else begin
            o_data.token_kind = tcl_pkg::KIND_END;
            o_data.last       = 1'b1;
        end
    end

    // Registers
    always_ff @(posedge i_clk) begin
        r_st.bytes <= n_st.bytes;
        r_q0.tok   <= n_q0.tok;
        r_q1.tok   <= n_q1.tok;
        if (!i_rst_n) begin
            r_st.count       <= '0;
            r_st.too_long    <= 1'b0;
            r_st.all_digits  <= 1'b1;
            r_st.ident_shape <= 1'b1;
            r_st.acc         <= '0;
            r_st.saturated   <= 1'b0;
            r_q0.has_tok     <= 1'b0;
            r_q0.has_end     <= 1'b0;
            r_q1.has_tok     <= 1'b0;
            r_q1.has_end     <= 1'b0;
        end else begin
            r_st.count       <= n_st.count;
            r_st.too_long    <= n_st.too_long;
            r_st.all_digits  <= n_st.all_digits;
            r_st.ident_shape <= n_st.ident_shape;
            r_st.acc         <= n_st.acc;
            r_st.saturated   <= n_st.saturated;
            r_q0.has_tok     <= n_q0.has_tok;
            r_q0.has_end     <= n_q0.has_end;
            r_q1.has_tok     <= n_q1.has_tok;
            r_q1.has_end     <= n_q1.has_end;
        end
    end

endmodule

>>> hdl/tcl_classify.sv
// ----------------------------------------------------------------------------
// tcl_classify
// Classifies the pending token: keyword or symbol, identifier, number or
// error, and builds the result fields.
// ----------------------------------------------------------------------------
module tcl_classify (
    input  tcl_pkg::t_tok_state i_st,
    output tcl_pkg::t_token     o_token
);

    logic                  word_hit;
    logic [4:0]            word_kind;
    logic [63:0]           name;

    // Exact match against the keyword and symbol table; the lowest table index wins
    always_comb begin
        logic                                 m;
        logic [8*tcl_pkg::WORD_MAX_CHARS-1:0] txt;
        logic [tcl_pkg::CNT_W-1:0]            len;
        word_hit  = 1'b0;
        word_kind = tcl_pkg::KIND_VAR;
        for (int k = tcl_pkg::NUM_WORDS - 1; k >= 0; k--) begin
            txt = tcl_pkg::word_text(k);
            len = tcl_pkg::word_len(k);
            m   = (i_st.count == len) && !i_st.too_long;
            for (int i = 0; i < tcl_pkg::WORD_MAX_CHARS; i++) begin
                if ((i < int'(len)) && (i < tcl_pkg::MAX_TOKEN_CHARS)) begin
                    if (i_st.bytes[i] != txt[8*(int'(len)-1-i) +: 8]) begin
                        m = 1'b0;
                    end
                end
            end
            if (m) begin
                word_hit  = 1'b1;
                word_kind = tcl_pkg::KIND_VAR + 5'(k);
            end
        end
    end

    // Identifier bytes, first character in the low byte, zero padded
    always_comb begin
        name = '0;
        for (int i = 0; i < tcl_pkg::MAX_TOKEN_CHARS; i++) begin
            if (i < int'(i_st.count)) begin
                name[8*i +: 8] = i_st.bytes[i];
            end
        end
    end

    // Priority: word, identifier, number, error
    always_comb begin
        o_token = '0;
        if (word_hit) begin
            o_token.kind = word_kind;
        end else if (i_st.ident_shape) begin
            o_token.kind        = tcl_pkg::KIND_IDENT;
            o_token.name_chars  = name;
            o_token.name_length = 4'(i_st.count);
            o_token.overflow    = i_st.too_long;
        end else if (i_st.all_digits) begin
            o_token.kind         = tcl_pkg::KIND_NUMBER;
            o_token.number_value = i_st.acc;
            o_token.overflow     = i_st.saturated;
        end else begin
            o_token.kind = tcl_pkg::KIND_ERROR;
        end
    end

endmodule
